// ===== design/tec_pkg.sv =====
// types, constants and a helper function for the text encoding classifier
package tec_pkg;

   typedef logic [2:0] encoding_type;

   localparam encoding_type ENC_ASCII   = 3'd0;
   localparam encoding_type ENC_UTF8    = 3'd1;
   localparam encoding_type ENC_UTF16LE = 3'd2;
   localparam encoding_type ENC_UTF16BE = 3'd3;
   localparam encoding_type ENC_UNKNOWN = 3'd4;

   localparam logic [6:0] CONF_ASCII   = 7'd100;
   localparam logic [6:0] CONF_UTF8    = 7'd98;
   localparam logic [6:0] CONF_UTF16   = 7'd95;
   localparam logic [6:0] CONF_UNKNOWN = 7'd20;

   localparam logic [2:0] COUNT_SAT = 3'd4;

   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_VAL   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'he0;
   localparam logic [7:0] LEAD2_VAL  = 8'hc0;
   localparam logic [7:0] LEAD3_MASK = 8'hf0;
   localparam logic [7:0] LEAD3_VAL  = 8'he0;
   localparam logic [7:0] LEAD4_MASK = 8'hf8;
   localparam logic [7:0] LEAD4_VAL  = 8'hf0;

   function automatic logic printable_byte(input logic [7:0] b);
      printable_byte = b inside {[8'h20:8'h7e], 8'h09, 8'h0a, 8'h0d};
   endfunction

endpackage

// ===== design/tec_req_if.sv =====
// input channel of the text encoding classifier
interface tec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output has_byte, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input has_byte, input last_byte,
                 output ready);
endinterface

// ===== design/tec_rsp_if.sv =====
// result channel of the text encoding classifier
interface tec_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] encoding;
   logic [6:0] confidence_pct;
   logic       lossy;

   modport source (output valid, output encoding, output confidence_pct, output lossy,
                   input ready);
   modport sink (input valid, input encoding, input confidence_pct, input lossy,
                 output ready);
endinterface

// ===== design/text_encoding_classifier.sv =====
// text encoding classifier top level: per-byte scan flags and result register
//
// channel  dir  payload                              accepted when
// req      in   data_byte, has_byte, last_byte       req.valid && req.ready
// rsp      out  encoding, confidence_pct, lossy      rsp.valid && rsp.ready
//
// one item per cycle while req.ready is high; the scan flags update in the cycle an item is taken
// a last item puts its result in the output register on the next edge
// req.ready is low only while a result waits and rsp.ready is low
// synchronous active-high reset returns the scan flags to their start state and clears the result valid
module text_encoding_classifier (
   input  logic      clock,
   input  logic      reset,
   tec_req_if.sink   req,
   tec_rsp_if.source rsp
);

   logic       le_valid_ff, le_valid_in;
   logic       be_valid_ff, be_valid_in;
   logic       utf8_valid_ff, utf8_valid_in;
   logic       saw_multi_ff, saw_multi_in;
   logic [1:0] cont_left_ff, cont_left_in;
   logic       odd_pos_ff, odd_pos_in;
   logic [2:0] count_ff, count_in;

   logic       rsp_valid_ff;
   logic [2:0] encoding_ff, encoding_in;
   logic [6:0] conf_ff, conf_in;
   logic       lossy_ff, lossy_in;

   logic       accept;
   logic       len_ok;
   logic [7:0] b;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;

   always_comb begin
      le_valid_in   = le_valid_ff;
      be_valid_in   = be_valid_ff;
      utf8_valid_in = utf8_valid_ff;
      saw_multi_in  = saw_multi_ff;
      cont_left_in  = cont_left_ff;
      odd_pos_in    = odd_pos_ff;
      count_in      = count_ff;
      encoding_in   = tec_pkg::ENC_ASCII;
      conf_in       = tec_pkg::CONF_ASCII;
      lossy_in      = 1'b0;
      len_ok        = 1'b0;

      if (req.has_byte) begin
         // utf-16 pair checks
         if (!odd_pos_ff) begin
            if (!tec_pkg::printable_byte(b)) le_valid_in = 1'b0;
            if (b != 8'h00) be_valid_in = 1'b0;
         end else begin
            if (b != 8'h00) le_valid_in = 1'b0;
            if (!tec_pkg::printable_byte(b)) be_valid_in = 1'b0;
         end
         odd_pos_in = !odd_pos_ff;
         if (count_ff < tec_pkg::COUNT_SAT) count_in = count_ff + 3'd1;

         // utf-8 checks
         if (utf8_valid_ff) begin
            if (cont_left_ff != 2'd0) begin
               if ((b & tec_pkg::CONT_MASK) != tec_pkg::CONT_VAL) utf8_valid_in = 1'b0;
               else cont_left_in = cont_left_ff - 2'd1;
            end else if (!b[7]) begin
               if (!tec_pkg::printable_byte(b)) utf8_valid_in = 1'b0;
            end else if ((b & tec_pkg::LEAD2_MASK) == tec_pkg::LEAD2_VAL) begin
               cont_left_in = 2'd1;
               saw_multi_in = 1'b1;
            end else if ((b & tec_pkg::LEAD3_MASK) == tec_pkg::LEAD3_VAL) begin
               cont_left_in = 2'd2;
               saw_multi_in = 1'b1;
            end else if ((b & tec_pkg::LEAD4_MASK) == tec_pkg::LEAD4_VAL) begin
               cont_left_in = 2'd3;
               saw_multi_in = 1'b1;
            end else begin
               utf8_valid_in = 1'b0;
            end
         end
      end

      len_ok = (count_in >= tec_pkg::COUNT_SAT) && !odd_pos_in;
      if (count_in == 3'd0) begin
         encoding_in = tec_pkg::ENC_ASCII;
         conf_in     = tec_pkg::CONF_ASCII;
      end else if (len_ok && le_valid_in) begin
         encoding_in = tec_pkg::ENC_UTF16LE;
         conf_in     = tec_pkg::CONF_UTF16;
      end else if (len_ok && be_valid_in) begin
         encoding_in = tec_pkg::ENC_UTF16BE;
         conf_in     = tec_pkg::CONF_UTF16;
      end else if (utf8_valid_in && cont_left_in == 2'd0) begin
         if (saw_multi_in) begin
            encoding_in = tec_pkg::ENC_UTF8;
            conf_in     = tec_pkg::CONF_UTF8;
         end else begin
            encoding_in = tec_pkg::ENC_ASCII;
            conf_in     = tec_pkg::CONF_ASCII;
         end
      end else begin
         encoding_in = tec_pkg::ENC_UNKNOWN;
         conf_in     = tec_pkg::CONF_UNKNOWN;
         lossy_in    = 1'b1;
      end

      // end of string returns the scan to its start
      if (req.last_byte) begin
         le_valid_in   = 1'b1;
         be_valid_in   = 1'b1;
         utf8_valid_in = 1'b1;
         saw_multi_in  = 1'b0;
         cont_left_in  = 2'd0;
         odd_pos_in    = 1'b0;
         count_in      = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         le_valid_ff   <= 1'b1;
         be_valid_ff   <= 1'b1;
         utf8_valid_ff <= 1'b1;
         saw_multi_ff  <= 1'b0;
         cont_left_ff  <= 2'd0;
         odd_pos_ff    <= 1'b0;
         count_ff      <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            le_valid_ff   <= le_valid_in;
            be_valid_ff   <= be_valid_in;
            utf8_valid_ff <= utf8_valid_in;
            saw_multi_ff  <= saw_multi_in;
            cont_left_ff  <= cont_left_in;
            odd_pos_ff    <= odd_pos_in;
            count_ff      <= count_in;
         end
         if (accept && req.last_byte) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.last_byte) begin
         encoding_ff <= encoding_in;
         conf_ff     <= conf_in;
         lossy_ff    <= lossy_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.encoding       = encoding_ff;
   assign rsp.confidence_pct = conf_ff;
   assign rsp.lossy          = lossy_ff;

endmodule

// ===== tb/text_encoding_classifier_test.sv =====
// self-checking testbench for the text encoding classifier
module text_encoding_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      tec_pkg::encoding_type enc;
      logic [6:0]            conf;
      logic                  lossy;
   } verdict_type;

   class verdict_tracker_type;
      verdict_type  expected_verdicts[$];
      int           failures = 0;
      logic         le_ok, be_ok, u8_ok, multibyte_seen, odd_pos;
      logic [1:0]   cont_owed;
      logic [2:0]   seen_count;

      function new();
         clear_scan();
      endfunction

      function void clear_scan();
         le_ok = 1'b1;
         be_ok = 1'b1;
         u8_ok = 1'b1;
         multibyte_seen = 1'b0;
         cont_owed = 2'd0;
         odd_pos = 1'b0;
         seen_count = 3'd0;
      endfunction

      function logic is_text_byte(logic [7:0] b);
         return (b >= 8'h20 && b <= 8'h7e) || b == 8'h09 || b == 8'h0a || b == 8'h0d;
      endfunction

      function void scan_byte(logic [7:0] b);
         if (!odd_pos) begin
            if (!is_text_byte(b)) le_ok = 1'b0;
            if (b != 8'h00) be_ok = 1'b0;
         end else begin
            if (b != 8'h00) le_ok = 1'b0;
            if (!is_text_byte(b)) be_ok = 1'b0;
         end
         odd_pos = !odd_pos;
         if (seen_count < tec_pkg::COUNT_SAT) seen_count++;
         if (!u8_ok) return;
         if (cont_owed != 2'd0) begin
            if ((b & tec_pkg::CONT_MASK) != tec_pkg::CONT_VAL) u8_ok = 1'b0;
            else cont_owed--;
         end else if (b < 8'h80) begin
            if (!is_text_byte(b)) u8_ok = 1'b0;
         end else if ((b & tec_pkg::LEAD2_MASK) == tec_pkg::LEAD2_VAL) begin
            cont_owed = 2'd1;
            multibyte_seen = 1'b1;
         end else if ((b & tec_pkg::LEAD3_MASK) == tec_pkg::LEAD3_VAL) begin
            cont_owed = 2'd2;
            multibyte_seen = 1'b1;
         end else if ((b & tec_pkg::LEAD4_MASK) == tec_pkg::LEAD4_VAL) begin
            cont_owed = 2'd3;
            multibyte_seen = 1'b1;
         end else begin
            u8_ok = 1'b0;
         end
      endfunction

      function void note_item(logic [7:0] b, logic has, logic last);
         verdict_type v;
         logic        pair_len_ok;
         if (has) scan_byte(b);
         if (!last) return;
         pair_len_ok = (seen_count >= tec_pkg::COUNT_SAT) && !odd_pos;
         if (seen_count == 3'd0) begin
            v.enc = tec_pkg::ENC_ASCII;   v.conf = tec_pkg::CONF_ASCII;
         end else if (pair_len_ok && le_ok) begin
            v.enc = tec_pkg::ENC_UTF16LE; v.conf = tec_pkg::CONF_UTF16;
         end else if (pair_len_ok && be_ok) begin
            v.enc = tec_pkg::ENC_UTF16BE; v.conf = tec_pkg::CONF_UTF16;
         end else if (u8_ok && cont_owed == 2'd0) begin
            if (multibyte_seen) begin
               v.enc = tec_pkg::ENC_UTF8;  v.conf = tec_pkg::CONF_UTF8;
            end else begin
               v.enc = tec_pkg::ENC_ASCII; v.conf = tec_pkg::CONF_ASCII;
            end
         end else begin
            v.enc = tec_pkg::ENC_UNKNOWN; v.conf = tec_pkg::CONF_UNKNOWN;
         end
         v.lossy = (v.enc == tec_pkg::ENC_UNKNOWN);
         expected_verdicts.insert(expected_verdicts.size(), v);
         clear_scan();
      endfunction

      function void check_verdict(logic [2:0] enc, logic [6:0] conf, logic lossy);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            $error("result with no item pending: encoding %0d", enc);
            failures++;
            return;
         end
         v = expected_verdicts.pop_front();
         if (enc !== v.enc) begin
            $error("encoding: expected %0d, got %0d", v.enc, enc);
            failures++;
         end
         if (conf !== v.conf) begin
            $error("confidence_pct: expected %0d, got %0d", v.conf, conf);
            failures++;
         end
         if (lossy !== v.lossy) begin
            $error("lossy: expected %0d, got %0d", v.lossy, lossy);
            failures++;
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   tec_req_if req_ch();
   tec_rsp_if rsp_ch();

   text_encoding_classifier dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   verdict_tracker_type tracker = new();

   logic [7:0] text_q[$];
   int         item_count = 0;
   int         send_mode = 1;
   int         take_mode = 1;
   bit         hold_rsp = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            tracker.note_item(req_ch.data_byte, req_ch.has_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_verdict(rsp_ch.encoding, rsp_ch.confidence_pct, rsp_ch.lossy);
      end
   end

   function int draw_gap(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return $urandom_range(0, 2);
      endcase
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if ($urandom_range(0, 7) == 0) take_mode = $urandom_range(0, 2);
         gap = draw_gap(take_mode);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send(logic [7:0] b, logic has, logic last);
      int gap;
      gap = draw_gap(send_mode);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.has_byte  <= has;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (has || last) item_count++;
   endtask

   task automatic play_string(bit sep_last);
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send(text_q[i], 1'b1, (i == n - 1) && !sep_last);
      end
      if (sep_last || n == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic void append_byte(logic [7:0] v);
      text_q.insert(text_q.size(), v);
   endfunction

   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 19))
         0: return 8'h09;
         1: return 8'h0a;
         2: return 8'h0d;
         default: return 8'($urandom_range(8'h20, 8'h7e));
      endcase
   endfunction

   function automatic void push_ascii(int n);
      repeat (n) append_byte(text_byte());
   endfunction

   function automatic void push_utf8(int n);
      repeat (n) begin
         case ($urandom_range(1, 4))
            1: append_byte(text_byte());
            2: begin
               append_byte({3'b110, 5'($urandom)});
               append_byte({2'b10, 6'($urandom)});
            end
            3: begin
               append_byte({4'b1110, 4'($urandom)});
               repeat (2) append_byte({2'b10, 6'($urandom)});
            end
            default: begin
               append_byte({5'b11110, 3'($urandom)});
               repeat (3) append_byte({2'b10, 6'($urandom)});
            end
         endcase
      end
   endfunction

   function automatic void push_utf16(int pairs, bit big_end);
      logic [7:0] c;
      repeat (pairs) begin
         c = text_byte();
         if (big_end) begin
            append_byte(8'h00);
            append_byte(c);
         end else begin
            append_byte(c);
            append_byte(8'h00);
         end
      end
   endfunction

   function automatic void push_noise(int n);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
   endfunction

   // truncate, corrupt one byte or append an odd byte
   function automatic void break_string();
      if (text_q.size() == 0) begin
         push_noise(1);
         return;
      end
      case ($urandom_range(0, 2))
         0: void'(text_q.pop_back());
         1: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
         default: append_byte(text_byte());
      endcase
   endfunction

   task automatic play_bytes(bit sep_last, input logic [7:0] bytes[$]);
      text_q = bytes;
      play_string(sep_last);
   endtask

   initial begin
      bit held, paused;
      held             = 0;
      paused           = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.has_byte  <= 1'b0;
      req_ch.last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings
      text_q.delete();
      play_string(1'b0);
      send(8'hff, 1'b0, 1'b0);
      send(8'h7e, 1'b1, 1'b1);
      send(8'h09, 1'b1, 1'b0);
      send(8'h00, 1'b0, 1'b1);
      play_bytes(1'b0, '{8'h09, 8'h00, 8'h7e, 8'h00});
      play_bytes(1'b0, '{8'h00, 8'h20, 8'h00, 8'h0d});
      play_bytes(1'b0, '{8'hc3, 8'ha9});
      play_bytes(1'b0, '{8'he2, 8'h82});
      play_bytes(1'b0, '{8'hff});
      play_bytes(1'b0, '{8'h00});
      play_bytes(1'b0, '{8'hf0, 8'h9f, 8'h98, 8'h80});
      drain();

      // random strings
      while (item_count < 1350) begin
         if ($urandom_range(0, 15) == 0) send_mode = $urandom_range(0, 2);
         text_q.delete();
         case ($urandom_range(0, 9))
            0, 1: push_ascii($urandom_range(0, 12));
            2, 3, 4: push_utf8($urandom_range(1, 6));
            5, 6: push_utf16($urandom_range(1, 6), 1'($urandom_range(0, 1)));
            7: push_noise($urandom_range(1, 8));
            default: begin
               if ($urandom_range(0, 1)) push_utf8($urandom_range(1, 5));
               else push_utf16($urandom_range(2, 5), 1'($urandom_range(0, 1)));
               break_string();
            end
         endcase
         play_string($urandom_range(0, 3) == 0);

         if (!held && item_count >= 500) begin
            held = 1;
            send_mode = 0;
            hold_rsp = 1;
            repeat (30) begin
               text_q.delete();
               push_ascii($urandom_range(0, 3));
               play_string(1'b0);
            end
         end
         if (!paused && item_count >= 900) begin
            paused = 1;
            drain();
         end
      end
      drain();
      repeat (10) @(posedge clock);

      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
